// ----- rtl/bcpu_pkg.sv -----
// bcpu_pkg: shared types, codes and sizing constants for the byte cpu execute unit
// no dependencies; imported by bcpu_divider, byte_cpu_execute_unit_core, byte_cpu_exec_checker and the testbench
package bcpu_pkg;

   // sizing of the machine state
   localparam int REG_COUNT   = 8;
   localparam int MEM_DEPTH   = 64;
   localparam int STACK_DEPTH = 8;

   localparam int DATA_W  = 8;
   localparam int REG_AW  = $clog2(REG_COUNT);
   localparam int MEM_AW  = $clog2(MEM_DEPTH);
   localparam int STK_AW  = $clog2(STACK_DEPTH);
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int CNT_W   = 4;
   localparam int RES_W   = 2 * DATA_W;
   localparam int MAP_N   = 2 ** DATA_W;

   localparam int BYTE_MAX = 127;
   localparam int BYTE_MIN = -128;
   localparam int ROT_MASK = 7;

   typedef enum logic [4:0] {
      ACT_INPUT      = 5'd0,
      ACT_DISPLAY    = 5'd1,
      ACT_MOVE       = 5'd2,
      ACT_LOAD       = 5'd3,
      ACT_STORE      = 5'd4,
      ACT_INC        = 5'd5,
      ACT_DEC        = 5'd6,
      ACT_ADD        = 5'd7,
      ACT_SUB        = 5'd8,
      ACT_MUL        = 5'd9,
      ACT_DIV        = 5'd10,
      ACT_SHL        = 5'd11,
      ACT_SHR        = 5'd12,
      ACT_ROL        = 5'd13,
      ACT_ROR        = 5'd14,
      ACT_PUSH       = 5'd15,
      ACT_POP        = 5'd16,
      ACT_CLEAR_FLAG = 5'd17
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_DIV_ZERO  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSEL_CARRY     = 2'd0,
      FSEL_UNDERFLOW = 2'd1,
      FSEL_OVERFLOW  = 2'd2,
      FSEL_ZERO      = 2'd3
   } flag_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic over;
      logic under;
      logic zero;
      logic carry;
   } flags_type;

   // byte value to register index and memory address, reduced modulo the sizes
   typedef logic [MAP_N-1:0][REG_AW-1:0] reg_map_type;
   typedef logic [MAP_N-1:0][MEM_AW-1:0] mem_map_type;

   function automatic reg_map_type build_reg_map();
      reg_map_type m;
      for (int i = 0; i < MAP_N; i++) begin
         m[i] = REG_AW'(i % REG_COUNT);
      end
      return m;
   endfunction

   function automatic mem_map_type build_mem_map();
      mem_map_type m;
      for (int i = 0; i < MAP_N; i++) begin
         m[i] = MEM_AW'(i % MEM_DEPTH);
      end
      return m;
   endfunction

   localparam reg_map_type REG_MAP = build_reg_map();
   localparam mem_map_type MEM_MAP = build_mem_map();

endpackage

// ----- rtl/byte_cpu_execute_unit_core.sv -----
// byte_cpu_execute_unit_core: top level of the byte cpu execute unit
// depends on bcpu_pkg and bcpu_divider
//
// executes one decoded instruction per request and returns exactly one
// response carrying the status, the four flags and, for display, the register
// value. register file, data memory and stack live in synchronous memories
// with registered read data; register file and data memory read as zero
// until written (per-entry valid bits, cleared by reset, no clearing pass).
// requests are handled one at a time: accept, memory read, execute, commit.
// divide adds a pass through the bit-serial divider, and shifts and rotates
// add a shift loop, one bit position per cycle (rotates use count mod 8).
// the response sits in an output register, so a commit only waits when the
// previous response has not yet been taken.
module byte_cpu_execute_unit_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [4:0]                          req_action,
   input  logic [2:0]                          req_dest_reg,
   input  logic signed [7:0]                   req_source,
   input  logic [3:0]                          req_shift_count,
   input  logic [1:0]                          req_flag_select,
   input  logic signed [7:0]                   req_input_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_display_valid,
   output logic [2:0]                          rsp_display_reg,
   output logic signed [7:0]                   rsp_display_value,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_flag_overflow,
   output logic                                rsp_flag_underflow,
   output logic                                rsp_flag_zero,
   output logic                                rsp_flag_carry
);
   import bcpu_pkg::*;

   localparam logic signed [RES_W-1:0] R_MAX = RES_W'(BYTE_MAX);
   localparam logic signed [RES_W-1:0] R_MIN = RES_W'(BYTE_MIN);

   // flags from a full signed result
   function automatic flags_type flags_of(input logic signed [RES_W-1:0] r);
      flags_type f;
      f.over  = r > R_MAX;
      f.under = r < R_MIN;
      f.zero  = r == '0;
      f.carry = f.over | f.under;
      return f;
   endfunction

   // fsm
   state_type state_ff, state_in;

   // captured request
   logic [4:0]            action_ff;
   logic [REG_AW-1:0]     d_ff;
   logic [REG_AW-1:0]     s_ff;
   logic [MEM_AW-1:0]     addr_ff;
   logic [DATA_W-1:0]     source_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [1:0]            fsel_ff;
   logic [DATA_W-1:0]     inval_ff;

   // memories and their registered read data
   logic [DATA_W-1:0]     rf_mem_ff  [REG_COUNT];
   logic [DATA_W-1:0]     dm_mem_ff  [MEM_DEPTH];
   logic [DATA_W-1:0]     stk_mem_ff [STACK_DEPTH];
   logic [REG_COUNT-1:0]  rf_vld_ff;
   logic [MEM_DEPTH-1:0]  dm_vld_ff;
   logic [DATA_W-1:0]     rf_rd_a_ff, rf_rd_b_ff, dm_rd_ff, stk_rd_ff;
   logic                  rf_vld_a_ff, rf_vld_b_ff, dm_vld_rd_ff;

   // architectural state outside the memories
   logic [DEPTH_W-1:0]    depth_ff;
   flags_type             flags_ff;

   // execution results, committed in S_DONE
   logic [DATA_W-1:0]     wb_data_ff;
   flags_type             flags_nx_ff;
   status_type            status_ff;
   logic [CNT_W-1:0]      sh_cnt_ff;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_dv_ff;
   logic [2:0]            rsp_dreg_ff;
   logic [DATA_W-1:0]     rsp_dval_ff;
   status_type            rsp_status_ff;
   flags_type             rsp_flags_ff;

   // fsm outputs
   logic                  accept;
   logic                  commit;
   logic                  div_start;
   logic                  out_free;

   // write enables at commit
   logic                  rf_we, dm_we, stk_we, pop_ok;

   // execute stage logic
   logic [DATA_W-1:0]     a_val, b_val, dm_val;
   logic signed [RES_W-1:0] a_ext, b_ext, arith_r;
   logic                  is_arith, is_shift, b_zero;
   logic [DATA_W-1:0]     exec_data;
   flags_type             exec_flags;
   status_type            exec_status;
   logic [CNT_W-1:0]      exec_steps;
   logic [STK_AW-1:0]     stk_rd_idx;
   logic [DATA_W-1:0]     shift_one;

   // divider
   logic                  div_done;
   logic signed [DATA_W:0] div_q;

   // ------------------------------------------------------------------
   // read data, gated by valid bits so unwritten entries read as zero
   // ------------------------------------------------------------------
   assign a_val  = rf_vld_a_ff  ? rf_rd_a_ff : '0;
   assign b_val  = rf_vld_b_ff  ? rf_rd_b_ff : '0;
   assign dm_val = dm_vld_rd_ff ? dm_rd_ff   : '0;
   assign b_zero = b_val == '0;

   assign a_ext   = RES_W'($signed(a_val));
   assign b_ext   = RES_W'($signed(b_val));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // pop reads the entry just below the top
   assign stk_rd_idx = STK_AW'(depth_ff - DEPTH_W'(1));

   // ------------------------------------------------------------------
   // fsm next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            if (action_ff == ACT_DIV && !b_zero) state_in = S_DIV;
            else if (is_shift) state_in = S_SHIFT;
            else state_in = S_DONE;
         end
         S_DIV: begin
            if (div_done) state_in = S_DONE;
         end
         S_SHIFT: begin
            if (sh_cnt_ff == '0) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // fsm outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_EXEC: div_start = (action_ff == ACT_DIV) && !b_zero;
         S_DONE: commit    = out_free;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // capture the request, indices reduced through the constant maps
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         d_ff      <= REG_MAP[DATA_W'(req_dest_reg)];
         s_ff      <= REG_MAP[$unsigned(req_source)];
         addr_ff   <= MEM_MAP[$unsigned(req_source)];
         source_ff <= $unsigned(req_source);
         count_ff  <= req_shift_count;
         fsel_ff   <= req_flag_select;
         inval_ff  <= $unsigned(req_input_value);
      end
   end

   // ------------------------------------------------------------------
   // execute: instruction decode and combinational datapath
   // ------------------------------------------------------------------
   always_comb begin
      is_arith    = 1'b0;
      is_shift    = 1'b0;
      arith_r     = '0;
      exec_data   = a_val;
      exec_flags  = flags_ff;
      exec_status = ST_OK;
      exec_steps  = count_ff;
      case (action_ff)
         ACT_INPUT: exec_data = inval_ff;
         ACT_MOVE:  exec_data = source_ff;
         ACT_LOAD:  exec_data = dm_val;
         ACT_INC: begin
            is_arith = 1'b1;
            arith_r  = a_ext + RES_W'(1);
         end
         ACT_DEC: begin
            is_arith = 1'b1;
            arith_r  = a_ext - RES_W'(1);
         end
         ACT_ADD: begin
            is_arith = 1'b1;
            arith_r  = a_ext + b_ext;
         end
         ACT_SUB: begin
            is_arith = 1'b1;
            arith_r  = a_ext - b_ext;
         end
         ACT_MUL: begin
            is_arith = 1'b1;
            arith_r  = a_ext * b_ext;
         end
         ACT_DIV: begin
            if (b_zero) exec_status = ST_DIV_ZERO;
         end
         ACT_SHL, ACT_SHR: is_shift = 1'b1;
         ACT_ROL, ACT_ROR: begin
            is_shift   = 1'b1;
            exec_steps = count_ff & CNT_W'(ROT_MASK);
         end
         ACT_PUSH: begin
            if (depth_ff >= DEPTH_W'(STACK_DEPTH)) exec_status = ST_OVERFLOW;
         end
         ACT_POP: begin
            if (depth_ff == '0) exec_status = ST_UNDERFLOW;
            exec_data = stk_rd_ff;
         end
         ACT_CLEAR_FLAG: begin
            case (fsel_ff)
               FSEL_CARRY:     exec_flags.carry = 1'b0;
               FSEL_UNDERFLOW: exec_flags.under = 1'b0;
               FSEL_OVERFLOW:  exec_flags.over  = 1'b0;
               FSEL_ZERO:      exec_flags.zero  = 1'b0;
               default: ;
            endcase
         end
         default: ;
      endcase
      if (is_arith) begin
         exec_data  = arith_r[DATA_W-1:0];
         exec_flags = flags_of(arith_r);
      end
   end

   // one bit position per cycle
   always_comb begin
      case (action_ff)
         ACT_SHL: shift_one = {wb_data_ff[DATA_W-2:0], 1'b0};
         ACT_SHR: shift_one = {1'b0, wb_data_ff[DATA_W-1:1]};
         ACT_ROL: shift_one = {wb_data_ff[DATA_W-2:0], wb_data_ff[DATA_W-1]};
         ACT_ROR: shift_one = {wb_data_ff[0], wb_data_ff[DATA_W-1:1]};
         default: shift_one = wb_data_ff;
      endcase
   end

   // result registers, filled by execute, divider or the shift loop
   always_ff @(posedge clock) begin
      case (state_ff)
         S_EXEC: begin
            wb_data_ff  <= exec_data;
            flags_nx_ff <= exec_flags;
            status_ff   <= exec_status;
            sh_cnt_ff   <= exec_steps;
         end
         S_DIV: begin
            if (div_done) begin
               wb_data_ff  <= div_q[DATA_W-1:0];
               flags_nx_ff <= flags_of(RES_W'(div_q));
            end
         end
         S_SHIFT: begin
            if (sh_cnt_ff != '0) begin
               wb_data_ff <= shift_one;
               sh_cnt_ff  <= sh_cnt_ff - CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   bcpu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ($signed(a_val)),
      .divisor  ($signed(b_val)),
      .done     (div_done),
      .quotient (div_q)
   );

   // ------------------------------------------------------------------
   // commit: write enables
   // ------------------------------------------------------------------
   always_comb begin
      rf_we  = 1'b0;
      dm_we  = 1'b0;
      stk_we = 1'b0;
      pop_ok = 1'b0;
      if (commit && status_ff == ST_OK) begin
         case (action_ff)
            ACT_INPUT, ACT_MOVE, ACT_LOAD, ACT_INC, ACT_DEC, ACT_ADD,
            ACT_SUB, ACT_MUL, ACT_DIV, ACT_SHL, ACT_SHR, ACT_ROL,
            ACT_ROR: rf_we = 1'b1;
            ACT_STORE: dm_we = 1'b1;
            ACT_PUSH:  stk_we = 1'b1;
            ACT_POP: begin
               rf_we  = 1'b1;
               pop_ok = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // register file: two read ports, one write port
   always_ff @(posedge clock) begin
      if (rf_we) rf_mem_ff[d_ff] <= wb_data_ff;
      rf_rd_a_ff <= rf_mem_ff[d_ff];
      rf_rd_b_ff <= rf_mem_ff[s_ff];
   end

   // data memory: one read port, one write port (store writes the subject register)
   always_ff @(posedge clock) begin
      if (dm_we) dm_mem_ff[addr_ff] <= a_val;
      dm_rd_ff <= dm_mem_ff[addr_ff];
   end

   // stack store: push writes at the depth, pop reads below it
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem_ff[depth_ff[STK_AW-1:0]] <= a_val;
      stk_rd_ff <= stk_mem_ff[stk_rd_idx];
   end

   // valid bits, depth and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff    <= '0;
         dm_vld_ff    <= '0;
         rf_vld_a_ff  <= 1'b0;
         rf_vld_b_ff  <= 1'b0;
         dm_vld_rd_ff <= 1'b0;
         depth_ff     <= '0;
         flags_ff     <= '0;
      end else begin
         rf_vld_a_ff  <= rf_vld_ff[d_ff];
         rf_vld_b_ff  <= rf_vld_ff[s_ff];
         dm_vld_rd_ff <= dm_vld_ff[addr_ff];
         if (rf_we) rf_vld_ff[d_ff] <= 1'b1;
         if (dm_we) dm_vld_ff[addr_ff] <= 1'b1;
         if (stk_we) depth_ff <= depth_ff + DEPTH_W'(1);
         else if (pop_ok) depth_ff <= depth_ff - DEPTH_W'(1);
         if (commit) flags_ff <= flags_nx_ff;
      end
   end

   // ------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (commit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= status_ff;
         rsp_flags_ff  <= flags_nx_ff;
         if (action_ff == ACT_DISPLAY) begin
            rsp_dv_ff   <= 1'b1;
            rsp_dreg_ff <= 3'(d_ff);
            rsp_dval_ff <= a_val;
         end else begin
            rsp_dv_ff   <= 1'b0;
            rsp_dreg_ff <= '0;
            rsp_dval_ff <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_display_valid  = rsp_dv_ff;
   assign rsp_display_reg    = rsp_dreg_ff;
   assign rsp_display_value  = $signed(rsp_dval_ff);
   assign rsp_status         = rsp_status_ff;
   assign rsp_flag_overflow  = rsp_flags_ff.over;
   assign rsp_flag_underflow = rsp_flags_ff.under;
   assign rsp_flag_zero      = rsp_flags_ff.zero;
   assign rsp_flag_carry     = rsp_flags_ff.carry;

`ifndef SYNTHESIS
   // stack depth never runs past its capacity
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack depth above capacity");

   // a commit writes at most one store
   a_one_store: assert property (@(posedge clock) disable iff (reset)
      $onehot0({rf_we & ~pop_ok, dm_we, stk_we, pop_ok}))
      else $error("more than one store written at commit");

   // an error status leaves all state alone
   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      (commit && status_ff != ST_OK) |-> !(rf_we || dm_we || stk_we || pop_ok))
      else $error("state written on error status");

   // depth only moves at a commit
   a_depth_commit: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(depth_ff))
      else $error("stack depth changed outside commit");

   // non-display responses carry a zero display payload
   a_display_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_dv_ff) |-> (rsp_dreg_ff == '0 && rsp_dval_ff == '0))
      else $error("display payload set on non-display response");
`endif

endmodule

// ----- rtl/bcpu_divider.sv -----
// bcpu_divider: signed byte divider, restoring, one quotient bit per cycle
// depends on bcpu_pkg; quotient truncates toward zero and spans -128 to 128
module bcpu_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [bcpu_pkg::DATA_W-1:0]    dividend,
   input  logic signed [bcpu_pkg::DATA_W-1:0]    divisor,
   output logic                                  done,
   output logic signed [bcpu_pkg::DATA_W:0]      quotient
);
   import bcpu_pkg::*;

   localparam int STEP_W = $clog2(DATA_W + 1);

   logic                     busy_ff;
   logic                     done_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [DATA_W:0]          rem_ff;
   logic [DATA_W-1:0]        quo_ff;
   logic [DATA_W-1:0]        dvs_ff;
   logic                     neg_ff;
   logic signed [DATA_W:0]   quot_ff;

   logic [DATA_W:0]          rem_sh;
   logic                     fits;
   logic [DATA_W:0]          rem_in;
   logic [DATA_W-1:0]        quo_in;
   logic [DATA_W:0]          quo_ext;

   always_comb begin
      rem_sh  = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      rem_in  = fits ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
      quo_in  = {quo_ff[DATA_W-2:0], fits};
      quo_ext = {1'b0, quo_in};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DATA_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath on magnitudes
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend[DATA_W-1] ? DATA_W'(-dividend) : dividend;
         dvs_ff <= divisor[DATA_W-1] ? DATA_W'(-divisor) : divisor;
         neg_ff <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         if (step_ff == STEP_W'(1)) begin
            quot_ff <= neg_ff ? $signed(-quo_ext) : $signed(quo_ext);
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- sim/byte_cpu_exec_checker.sv -----
`timescale 1ns / 1ps
// byte_cpu_exec_checker: watches the request and response channels of the byte cpu
// execute unit, keeps its own copy of the machine state and checks every response
// depends on bcpu_pkg for the action, status and flag codes and the sizes
module byte_cpu_exec_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [4:0]        req_action,
   input  logic [2:0]        req_dest_reg,
   input  logic [7:0]        req_source,
   input  logic [3:0]        req_shift_count,
   input  logic [1:0]        req_flag_select,
   input  logic [7:0]        req_input_value,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_display_valid,
   input  logic [2:0]        rsp_display_reg,
   input  logic signed [7:0] rsp_display_value,
   input  logic [1:0]        rsp_status,
   input  logic              rsp_flag_overflow,
   input  logic              rsp_flag_underflow,
   input  logic              rsp_flag_zero,
   input  logic              rsp_flag_carry,
   output int                fail_count,
   output int                pending
);
   import bcpu_pkg::*;

   typedef struct packed {
      logic       disp_valid;
      logic [2:0] disp_reg;
      logic [7:0] disp_value;
      logic [1:0] status;
      flags_type  flags;
   } response_type;

   logic [7:0]   regs [REG_COUNT];
   logic [7:0]   mem_bytes [MEM_DEPTH];
   logic [7:0]   stack_bytes [STACK_DEPTH];
   int           stack_fill;
   flags_type    flags;
   response_type owed_responses [$];
   int           errors_seen;

   function automatic logic [7:0] shifted_byte(logic [7:0] v, logic [4:0] act,
                                               logic [3:0] cnt);
      logic [15:0] twice;
      int          n;
      twice = {v, v};
      n = cnt & ROT_MASK;
      case (act)
         ACT_SHL: return (cnt >= 8) ? 8'h00 : v << cnt;
         ACT_SHR: return (cnt >= 8) ? 8'h00 : v >> cnt;
         ACT_ROL: begin
            twice = twice << n;
            return twice[15:8];
         end
         default: begin
            twice = twice >> n;
            return twice[7:0];
         end
      endcase
   endfunction

   // applies one instruction to the local state and returns the response it owes
   function automatic response_type execute_request(logic [4:0] act, logic [2:0] dest,
                                                    logic [7:0] src, logic [3:0] cnt,
                                                    logic [1:0] fsel, logic [7:0] inval);
      response_type rsp;
      int           d, s, addr, a, b, full;
      bit           arith;
      d = int'(dest) % REG_COUNT;
      s = int'(src) % REG_COUNT;
      addr = int'(src) % MEM_DEPTH;
      a = $signed(regs[d]);
      b = $signed(regs[s]);
      full = 0;
      arith = 1'b0;
      rsp = '0;
      case (act)
         ACT_INPUT:   regs[d] = inval;
         ACT_DISPLAY: begin
            rsp.disp_valid = 1'b1;
            rsp.disp_reg = 3'(d);
            rsp.disp_value = regs[d];
         end
         ACT_MOVE:    regs[d] = src;
         ACT_LOAD:    regs[d] = mem_bytes[addr];
         ACT_STORE:   mem_bytes[addr] = regs[d];
         ACT_INC:     begin full = a + 1; arith = 1'b1; end
         ACT_DEC:     begin full = a - 1; arith = 1'b1; end
         ACT_ADD:     begin full = a + b; arith = 1'b1; end
         ACT_SUB:     begin full = a - b; arith = 1'b1; end
         ACT_MUL:     begin full = a * b; arith = 1'b1; end
         ACT_DIV: begin
            if (b == 0) rsp.status = ST_DIV_ZERO;
            else begin
               full = a / b;
               arith = 1'b1;
            end
         end
         ACT_SHL, ACT_SHR, ACT_ROL, ACT_ROR: regs[d] = shifted_byte(regs[d], act, cnt);
         ACT_PUSH: begin
            if (stack_fill >= STACK_DEPTH) rsp.status = ST_OVERFLOW;
            else begin
               stack_bytes[stack_fill] = regs[d];
               stack_fill++;
            end
         end
         ACT_POP: begin
            if (stack_fill == 0) rsp.status = ST_UNDERFLOW;
            else begin
               stack_fill--;
               regs[d] = stack_bytes[stack_fill];
            end
         end
         ACT_CLEAR_FLAG: begin
            case (fsel)
               FSEL_CARRY:     flags.carry = 1'b0;
               FSEL_UNDERFLOW: flags.under = 1'b0;
               FSEL_OVERFLOW:  flags.over = 1'b0;
               default:        flags.zero = 1'b0;
            endcase
         end
         default: ;
      endcase
      if (arith) begin
         regs[d] = 8'(full);
         flags.over = full > BYTE_MAX;
         flags.under = full < BYTE_MIN;
         flags.zero = full == 0;
         flags.carry = flags.over || flags.under;
      end
      rsp.flags = flags;
      return rsp;
   endfunction

   task automatic note_error(input string msg);
      errors_seen++;
      $error("%s", msg);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) note_error($sformatf("%s: expected %0d, got %0d", name, want, got));
   endtask

   always @(posedge clock) begin : watch
      response_type want;
      if (reset) begin
         foreach (regs[i]) regs[i] = '0;
         foreach (mem_bytes[i]) mem_bytes[i] = '0;
         foreach (stack_bytes[i]) stack_bytes[i] = '0;
         stack_fill = 0;
         flags = '0;
         owed_responses.delete();
         errors_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               note_error("response with no request outstanding");
            end else begin
               want = owed_responses.pop_front();
               compare_field("display_valid", want.disp_valid, rsp_display_valid);
               compare_field("display_reg", want.disp_reg, rsp_display_reg);
               compare_field("display_value", $signed(want.disp_value), rsp_display_value);
               compare_field("status", want.status, rsp_status);
               compare_field("flag_overflow", want.flags.over, rsp_flag_overflow);
               compare_field("flag_underflow", want.flags.under, rsp_flag_underflow);
               compare_field("flag_zero", want.flags.zero, rsp_flag_zero);
               compare_field("flag_carry", want.flags.carry, rsp_flag_carry);
            end
         end
         if (req_valid && req_ready)
            owed_responses.push_back(execute_request(req_action, req_dest_reg, req_source,
                                                     req_shift_count, req_flag_select,
                                                     req_input_value));
      end
      pending <= owed_responses.size();
      fail_count <= errors_seen;
   end

endmodule

// ----- sim/tb_byte_cpu_execute_unit_core.sv -----
`timescale 1ns / 1ps
// tb_byte_cpu_execute_unit_core: feeds directed and random instruction streams to the
// byte cpu execute unit with random idling on both channels and prints the verdict
// depends on bcpu_pkg, byte_cpu_exec_checker and the block itself
module tb_byte_cpu_execute_unit_core;
   import bcpu_pkg::*;

   localparam int ITEM_TARGET   = 1950;
   localparam int QUIET_ITEMS   = 150;   // no idling on either side for the tail
   localparam int HOLD_AT       = 300;   // request count that triggers the long hold-off
   localparam int DRAIN_AT      = 1000;  // request count that triggers the sender pause
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 2000;  // cycles without any handshake before giving up
   localparam int SETTLE_CYCLES = 40;
   localparam logic [4:0] ACT_UNUSED_TOP = '1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [4:0]        req_action = '0;
   logic [2:0]        req_dest_reg = '0;
   logic signed [7:0] req_source = '0;
   logic [3:0]        req_shift_count = '0;
   logic [1:0]        req_flag_select = '0;
   logic signed [7:0] req_input_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_display_valid;
   logic [2:0]        rsp_display_reg;
   logic signed [7:0] rsp_display_value;
   logic [1:0]        rsp_status;
   logic              rsp_flag_overflow;
   logic              rsp_flag_underflow;
   logic              rsp_flag_zero;
   logic              rsp_flag_carry;
   int                fail_count;
   int                pending;

   int items_sent = 0;
   int calm_items = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_off_go = 1'b0;

   byte_cpu_execute_unit_core dut (.*);

   // predicts and compares every response, reports the failure count back here
   byte_cpu_exec_checker u_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog: only cycles in which neither channel moves count toward the limit
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tb_byte_cpu_execute_unit_core: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one value in two is a boundary or near-zero byte, so zero divisors and the
   // overflow edges come up often
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 13))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'hFF;
         3: return 8'h7F;
         4: return 8'h80;
         5: return 8'h02;
         6: return 8'hFE;
         default: return 8'($urandom);
      endcase
   endfunction

   // offers one request, holds it until accepted, then maybe leaves a gap
   task automatic issue(input logic [4:0] act, input logic [2:0] dest,
                        input logic [7:0] src, input logic [3:0] cnt,
                        input logic [1:0] fsel, input logic [7:0] inval);
      req_valid <= 1'b1;
      req_action <= act;
      req_dest_reg <= dest;
      req_source <= src;
      req_shift_count <= cnt;
      req_flag_select <= fsel;
      req_input_value <= inval;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      // calm stretches: back-to-back requests with no gaps at all
      if (calm_items > 0) begin
         calm_items--;
      end else if (!quiet && $urandom_range(0, 24) == 0) begin
         calm_items = $urandom_range(30, 80);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // response side: ready bursts, short stalls, and one long hold-off on demand
   initial begin : receiver
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_go) begin
            // long hold-off while the sender keeps offering, so the block backs up
            hold_off_go = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) repeat ($urandom_range(60, 150)) @(posedge clock);
            else repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [2:0] ra, rb;
      logic [4:0] op;
      logic [7:0] addr;
      int         n;
      bit         hold_done, drain_done;
      hold_done = 1'b0;
      drain_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: byte limits through inc and dec
      issue(ACT_INPUT, 3'd0, 8'h00, 4'd0, FSEL_CARRY, 8'h7F);
      issue(ACT_INC, 3'd0, 8'hFF, 4'hF, FSEL_ZERO, 8'h80);
      issue(ACT_INPUT, 3'd7, 8'hFF, 4'hF, FSEL_ZERO, 8'h80);
      issue(ACT_DEC, 3'd7, 8'h00, 4'd0, FSEL_CARRY, 8'h7F);
      // clear each flag in turn
      issue(ACT_CLEAR_FLAG, 3'd0, 8'h00, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_CLEAR_FLAG, 3'd0, 8'h00, 4'd0, FSEL_UNDERFLOW, 8'h00);
      issue(ACT_CLEAR_FLAG, 3'd0, 8'h00, 4'd0, FSEL_OVERFLOW, 8'h00);
      issue(ACT_CLEAR_FLAG, 3'd0, 8'h00, 4'd0, FSEL_ZERO, 8'h00);
      // -128 / -1 through a source index with high bits set, then divide by zero
      issue(ACT_MOVE, 3'd2, 8'hFF, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_DIV, 3'd0, 8'hFA, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_DIV, 3'd0, 8'h0B, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_MUL, 3'd0, 8'h00, 4'd0, FSEL_CARRY, 8'h00);
      // memory address wraps modulo the depth
      issue(ACT_STORE, 3'd7, 8'hFF, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_LOAD, 3'd5, 8'h3F, 4'd0, FSEL_CARRY, 8'h00);
      // long shifts clear, rotates take the count mod 8
      issue(ACT_SHL, 3'd5, 8'h00, 4'hF, FSEL_CARRY, 8'h00);
      issue(ACT_ROL, 3'd7, 8'h00, 4'd9, FSEL_CARRY, 8'h00);
      issue(ACT_ROR, 3'd7, 8'h00, 4'd3, FSEL_CARRY, 8'h00);
      issue(ACT_SHR, 3'd7, 8'h00, 4'd8, FSEL_CARRY, 8'h00);
      // pop from the empty stack
      issue(ACT_POP, 3'd4, 8'h00, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_ADD, 3'd1, 8'h02, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_SUB, 3'd1, 8'h07, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_PUSH, 3'd2, 8'h00, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_POP, 3'd6, 8'h00, 4'd0, FSEL_CARRY, 8'h00);
      issue(ACT_UNUSED_TOP, 3'd7, 8'hFF, 4'hF, FSEL_ZERO, 8'hFF);
      issue(ACT_DISPLAY, 3'd6, 8'h00, 4'd0, FSEL_CARRY, 8'h00);

      // random part: short instruction sequences with random content
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_off_go = 1'b1;
         end
         if (!drain_done && items_sent >= DRAIN_AT) begin
            // sender pause until every outstanding response has come back
            drain_done = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         ra = 3'($urandom);
         rb = 3'($urandom);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // any single instruction, now and then an unused code
               if ($urandom_range(0, 31) == 0)
                  op = 5'($urandom_range(ACT_CLEAR_FLAG + 1, ACT_UNUSED_TOP));
               else
                  op = 5'($urandom_range(ACT_INPUT, ACT_CLEAR_FLAG));
               issue(op, ra, 8'($urandom), 4'($urandom), 2'($urandom), pick_byte());
            end
            4: begin
               // push run, long enough at times to overfill the stack
               n = $urandom_range(1, STACK_DEPTH + 2);
               repeat (n) issue(ACT_PUSH, 3'($urandom), 8'($urandom), 4'($urandom),
                                2'($urandom), 8'($urandom));
            end
            5: begin
               // pop run, long enough at times to drain past empty
               n = $urandom_range(1, STACK_DEPTH + 2);
               repeat (n) issue(ACT_POP, 3'($urandom), 8'($urandom), 4'($urandom),
                                2'($urandom), 8'($urandom));
            end
            6: begin
               // load two operands, apply one arithmetic op, show the result
               op = 5'($urandom_range(ACT_INC, ACT_DIV));
               issue(ACT_INPUT, ra, 8'($urandom), 4'($urandom), 2'($urandom), pick_byte());
               issue(ACT_INPUT, rb, 8'($urandom), 4'($urandom), 2'($urandom), pick_byte());
               issue(op, ra, {5'($urandom), rb}, 4'($urandom), 2'($urandom), 8'($urandom));
               issue(ACT_DISPLAY, ra, 8'($urandom), 4'($urandom), 2'($urandom), 8'($urandom));
            end
            7: begin
               // store then load back through an alias of the same address
               addr = 8'($urandom);
               issue(ACT_MOVE, ra, pick_byte(), 4'($urandom), 2'($urandom), 8'($urandom));
               issue(ACT_STORE, ra, addr, 4'($urandom), 2'($urandom), 8'($urandom));
               issue(ACT_LOAD, rb, {2'($urandom), addr[5:0]}, 4'($urandom), 2'($urandom),
                     8'($urandom));
               issue(ACT_DISPLAY, rb, 8'($urandom), 4'($urandom), 2'($urandom), 8'($urandom));
            end
            8: begin
               // shift or rotate a known value and show it
               op = 5'($urandom_range(ACT_SHL, ACT_ROR));
               issue(ACT_INPUT, ra, 8'($urandom), 4'($urandom), 2'($urandom), pick_byte());
               issue(op, ra, 8'($urandom), 4'($urandom), 2'($urandom), 8'($urandom));
               issue(ACT_DISPLAY, ra, 8'($urandom), 4'($urandom), 2'($urandom), 8'($urandom));
            end
            default: begin
               // clear a flag after an op that probably set some
               op = 5'($urandom_range(ACT_INC, ACT_MUL));
               issue(op, ra, 8'($urandom), 4'($urandom), 2'($urandom), 8'($urandom));
               issue(ACT_CLEAR_FLAG, ra, 8'($urandom), 4'($urandom), 2'($urandom),
                     8'($urandom));
            end
         endcase
      end

      // wait for the last responses, then a short settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_byte_cpu_execute_unit_core: clean");
      end else begin
         $display("tb_byte_cpu_execute_unit_core: errors");
      end
      $finish;
   end

endmodule
